// ===== hw/rtl/jac_pkg.sv =====
// Shared types, constants and helper functions for the joystick axis conditioner.
package jac_pkg;

    localparam int NumAxesDefault = 4;

    localparam int AxisW   = 2;
    localparam int SampleW = 16;
    localparam int RawW    = 12;
    localparam int PosW    = 16;
    localparam int CfgIdxW = 3;
    localparam int WideW   = PosW + 2;

    typedef logic [AxisW-1:0]        t_axis;
    typedef logic [SampleW-1:0]      t_sample;
    typedef logic [RawW-1:0]         t_raw;
    typedef logic signed [PosW-1:0]  t_pos;
    typedef logic signed [WideW-1:0] t_wide;
    typedef logic [CfgIdxW-1:0]      t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_OFFSET_LX  = 3'd0;
    localparam t_cfg_idx CFG_OFFSET_LY  = 3'd1;
    localparam t_cfg_idx CFG_OFFSET_RX  = 3'd2;
    localparam t_cfg_idx CFG_OFFSET_RY  = 3'd3;
    localparam t_cfg_idx CFG_END_LOW    = 3'd4;
    localparam t_cfg_idx CFG_END_HIGH   = 3'd5;

    localparam t_raw AW_PREV_HIGH   = 12'd3850;
    localparam t_raw AW_NEW_LOW     = 12'd120;
    localparam t_raw AW_PREV_LOW    = 12'd250;
    localparam t_raw AW_NEW_HIGH    = 12'd3975;
    localparam t_raw RAW_MAX        = 12'd4095;
    localparam t_raw RAW_MID        = 12'd2048;
    localparam t_raw END_LOW_RESET  = 12'd10;
    localparam t_raw END_HIGH_RESET = 12'd4085;

    localparam t_pos POS_MAX     = 16'sh7FFF;
    localparam t_pos POS_MIN     = 16'sh8000;
    localparam t_pos POS_NEG_MAX = 16'sh8001;

    function automatic t_raw sat12(input t_sample s);
        t_raw res;
        res = (|s[SampleW-1:RawW]) ? RAW_MAX : s[RawW-1:0];
        return res;
    endfunction

    // Symmetric map of 0..4095 onto the signed 16-bit range.
    // Upper half: floor(d*32767/2047) = 16*d + floor(15*d/2047), where the
    // second term comes from a shift by 11 and one correction step.
    function automatic t_pos map_symmetric(input t_raw v);
        logic [RawW-2:0] d;
        logic [14:0]     x;
        logic [3:0]      q;
        logic [RawW-1:0] r;
        t_pos            res;
        d = v[RawW-2:0];
        x = {d, 4'b0000} - {4'b0000, d};
        q = x[14:11];
        r = {1'b0, x[10:0]} + {8'd0, q};
        if (r >= 12'd2047) begin
            q = q + 4'd1;
        end
        if (v == '0) begin
            res = POS_MIN;
        end else if (v == RAW_MAX) begin
            res = POS_MAX;
        end else if (v[RawW-1]) begin
            res = signed'({1'b0, d, 4'b0000} + {12'd0, q});
        end else begin
            res = signed'({1'b1, d, 4'b0000});
        end
        return res;
    endfunction

    function automatic t_pos clamp16(input t_wide x);
        t_pos res;
        if (x > t_wide'(POS_MAX)) begin
            res = POS_MAX;
        end else if (x < t_wide'(POS_MIN)) begin
            res = POS_MIN;
        end else begin
            res = x[PosW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/joystick_axis_conditioner.sv =====
// Joystick axis conditioner: median filter, anti-wrap, symmetric map, offset and end stops.
//
// One axis sample is taken per clock when the output side is not stalled. The sample
// is captured in an input register, then median, anti-wrap, mapping, offset clamp
// and end-stop logic run in one pass into the result register, which offers the result.
// The per-axis previous value lives in a small register file written, for a good read,
// as the sample moves into the result register, so a sample of the same axis right
// behind it already sees the new value. Configuration writes are always accepted and
// take effect at once; write them only while the block is idle.
module joystick_axis_conditioner #(
    parameter int NUM_AXES = jac_pkg::NumAxesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jac_pkg::t_axis     i_axis_sel,
    input  jac_pkg::t_sample   i_sample_first,
    input  jac_pkg::t_sample   i_sample_second,
    input  jac_pkg::t_sample   i_sample_third,
    input  logic               i_read_ok,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jac_pkg::t_axis     o_axis_out,
    output jac_pkg::t_pos      o_position,
    output jac_pkg::t_raw      o_filtered_raw,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  jac_pkg::t_cfg_idx  i_cfg_index,
    input  jac_pkg::t_pos      i_cfg_data
);
    import jac_pkg::*;

    // configuration
    t_pos r_offset [4];
    t_raw r_end_low;
    t_raw r_end_high;

    // per-axis filter state
    t_raw r_prev [NUM_AXES];

    // input register
    logic    r_in_valid;
    t_axis   r_in_axis;
    t_sample r_in_first;
    t_sample r_in_second;
    t_sample r_in_third;
    logic    r_in_ok;

    // result register
    logic  r_out_valid;
    t_axis r_out_axis;
    t_pos  r_out_pos;
    t_raw  r_out_filt;

    logic advance;
    t_raw s_a, s_b, s_c, s_lo, s_hi, s_med, s_prev;
    t_raw n_filt;
    t_pos s_mapped, s_signed, s_offset;
    t_wide s_diff;
    t_pos n_pos;
    logic s_is_y;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_offset[i] <= '0;
            end
            r_end_low  <= END_LOW_RESET;
            r_end_high <= END_HIGH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET_LX: r_offset[0] <= i_cfg_data;
                CFG_OFFSET_LY: r_offset[1] <= i_cfg_data;
                CFG_OFFSET_RX: r_offset[2] <= i_cfg_data;
                CFG_OFFSET_RY: r_offset[3] <= i_cfg_data;
                CFG_END_LOW:   r_end_low   <= i_cfg_data[RawW-1:0];
                CFG_END_HIGH:  r_end_high  <= i_cfg_data[RawW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_axis   <= i_axis_sel;
            r_in_first  <= i_sample_first;
            r_in_second <= i_sample_second;
            r_in_third  <= i_sample_third;
            r_in_ok     <= i_read_ok;
        end
    end

    // previous value for this axis; axes without a slot behave as mid scale
    always_comb begin
        s_prev = RAW_MID;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (int'(r_in_axis) == i) begin
                s_prev = r_prev[i];
            end
        end
    end

    always_comb begin
        s_a   = sat12(r_in_first);
        s_b   = sat12(r_in_second);
        s_c   = sat12(r_in_third);
        s_lo  = (s_a < s_b) ? s_a : s_b;
        s_hi  = (s_a < s_b) ? s_b : s_a;
        s_med = (s_c < s_lo) ? s_lo : ((s_c > s_hi) ? s_hi : s_c);

        // anti-wrap: a jump across the ends of the range sticks to the old side
        n_filt = s_med;
        if (s_prev > AW_PREV_HIGH && n_filt < AW_NEW_LOW) begin
            n_filt = RAW_MAX;
        end
        if (s_prev < AW_PREV_LOW && n_filt > AW_NEW_HIGH) begin
            n_filt = '0;
        end
        if (!r_in_ok) begin
            n_filt = s_prev;
        end

        s_is_y   = r_in_axis[0];
        s_offset = r_offset[r_in_axis];
        s_mapped = map_symmetric(n_filt);
        if (s_is_y) begin
            s_signed = (s_mapped == POS_MIN) ? POS_MAX : -s_mapped;
        end else begin
            s_signed = s_mapped;
        end
        if (!r_in_ok) begin
            s_signed = '0;
        end
        s_diff = {{(WideW-PosW){s_signed[PosW-1]}}, s_signed}
               - {{(WideW-PosW){s_offset[PosW-1]}}, s_offset};
        n_pos = clamp16(s_diff);

        if (r_in_ok) begin
            if (n_filt <= r_end_low) begin
                n_pos = s_is_y ? POS_MAX : POS_MIN;
            end else if (n_filt >= r_end_high) begin
                n_pos = s_is_y ? POS_NEG_MAX : POS_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_prev[i] <= RAW_MID;
            end
        end else if (advance && r_in_ok) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (int'(r_in_axis) == i) begin
                    r_prev[i] <= n_filt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_axis <= r_in_axis;
            r_out_pos  <= n_pos;
            r_out_filt <= n_filt;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_axis_out     = r_out_axis;
    assign o_position     = r_out_pos;
    assign o_filtered_raw = r_out_filt;

endmodule
